// ===== src/elapchk_pkg.sv =====
// Package with the constants, types and classification function of the ELAP frame checker.
`timescale 1ns / 1ps

package elapchk_pkg;

    // Frame geometry and counter limits
    localparam int MAX_FRAME_BYTES = 2048;
    localparam int OFFSET_W        = $clog2(MAX_FRAME_BYTES);
    localparam logic [OFFSET_W-1:0] OFFSET_MAX = OFFSET_W'(MAX_FRAME_BYTES - 1);
    localparam logic [10:0] MIN_FRAME_RESET = 11'd60;
    localparam int SLOT_COUNT = 12;

    // Byte offsets of the header fields, counted from the destination MAC
    localparam logic [OFFSET_W-1:0] OFS_LLC      = OFFSET_W'(14);
    localparam logic [OFFSET_W-1:0] OFS_CLASSIFY = OFFSET_W'(21);
    localparam logic [OFFSET_W-1:0] OFS_LENGTH   = OFFSET_W'(22);
    localparam logic [OFFSET_W-1:0] OFS_CHECKSUM = OFFSET_W'(24);
    localparam logic [OFFSET_W-1:0] OFS_BODY     = OFFSET_W'(26);
    localparam logic [OFFSET_W-1:0] OFS_DDP_END  = OFFSET_W'(34);
    localparam logic [OFFSET_W-1:0] OFS_AARP_A0  = OFFSET_W'(29);
    localparam logic [OFFSET_W-1:0] OFS_AARP_B   = OFFSET_W'(36);
    localparam logic [OFFSET_W-1:0] OFS_AARP_B1  = OFFSET_W'(39);
    localparam logic [OFFSET_W-1:0] OFS_AARP_C   = OFFSET_W'(46);
    localparam logic [OFFSET_W-1:0] OFS_AARP_C1  = OFFSET_W'(49);
    localparam logic [OFFSET_W-1:0] AARP_B_BASE  = OFFSET_W'(32);
    localparam logic [OFFSET_W-1:0] AARP_C_BASE  = OFFSET_W'(38);

    // Protocol constants
    localparam logic [7:0]  SAP_SNAP  = 8'hAA;
    localparam logic [7:0]  LLC_UI    = 8'h03;
    localparam logic [15:0] TYPE_DDP  = 16'h809B;
    localparam logic [15:0] TYPE_AARP = 16'h80F3;
    localparam logic [15:0] AARP_HW_ETHER = 16'h0001;
    localparam logic [7:0]  AARP_HW_LEN   = 8'd6;
    localparam logic [7:0]  AARP_PROTO_LEN = 8'd4;
    localparam logic [9:0]  DDP_HDR_SUM_SKIP = 10'd4;

    // Status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_BAD_SAP   = 3'd2;
    localparam logic [2:0] ST_BAD_CTRL  = 3'd3;
    localparam logic [2:0] ST_BAD_TYPE  = 3'd4;
    localparam logic [2:0] ST_BAD_SUM   = 3'd5;
    localparam logic [2:0] ST_BAD_AARP  = 3'd6;

    // Frame kinds
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_DDP  = 2'd1;
    localparam logic [1:0] KIND_AARP = 2'd2;

    typedef logic [SLOT_COUNT-1:0][7:0] slots_t;

    typedef struct packed {
        logic [2:0] err;
        logic [1:0] kind;
    } class_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  frame_kind;
        logic [9:0]  ddp_length;
        logic [3:0]  hop_count;
        logic [15:0] packet_code;
        logic [15:0] src_net;
        logic [15:0] dest_net;
        logic [7:0]  src_node;
        logic [7:0]  dest_node;
        logic [7:0]  src_socket;
        logic [7:0]  dest_socket;
    } result_t;

    // Classify a frame from its LLC/SNAP bytes held in slots 0 to 7.
    function automatic class_t classify(input slots_t s);
        class_t c;
        logic [15:0] ptype;
        ptype  = {s[6], s[7]};
        c.err  = ST_OK;
        c.kind = KIND_NONE;
        if (s[0] != SAP_SNAP || s[1] != SAP_SNAP)
        begin
            c.err = ST_BAD_SAP;
        end
        else if (s[2] != LLC_UI)
        begin
            c.err = ST_BAD_CTRL;
        end
        else if (ptype == TYPE_DDP && s[3] == 8'h08 && s[4] == 8'h00 && s[5] == 8'h07)
        begin
            c.kind = KIND_DDP;
        end
        else if (ptype == TYPE_AARP && s[3] == 8'h00 && s[4] == 8'h00 && s[5] == 8'h00)
        begin
            c.kind = KIND_AARP;
        end
        else
        begin
            c.err = ST_BAD_TYPE;
        end
        return c;
    endfunction

endpackage

// ===== src/elap_ddp_aarp_frame_checker.sv =====
// Top level of the byte-serial ELAP frame checker for DDP and AARP frames.
`timescale 1ns / 1ps

// The checker takes one frame byte per cycle on the frame channel, with last_byte
// marking the final byte, and delivers one result on the result channel in the cycle
// after the last byte is transferred. Every byte is handled in the cycle it is
// transferred: the offset decode, header capture and rotate-add checksum update are
// each a single short step, so the sustained rate is one byte per clock. The only
// stall is on a last byte while the previous result is still held and stalled by the
// consumer; bytes inside a frame are always taken. min_frame_reg resets to 60 and is
// written through cfg_we/cfg_wdata by the user between frames; the block does not enforce it.
module elap_ddp_aarp_frame_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [10:0] cfg_wdata,
    input  logic        frame_valid,
    output logic        frame_stall,
    input  logic [7:0]  frame_byte,
    input  logic        last_byte,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [2:0]  status,
    output logic [1:0]  frame_kind,
    output logic [9:0]  ddp_length,
    output logic [3:0]  hop_count,
    output logic [15:0] packet_code,
    output logic [15:0] src_net,
    output logic [15:0] dest_net,
    output logic [7:0]  src_node,
    output logic [7:0]  dest_node,
    output logic [7:0]  src_socket,
    output logic [7:0]  dest_socket
);

    localparam int OW = elapchk_pkg::OFFSET_W;

    logic [10:0]               min_frame_reg;
    logic [OW-1:0]             offset_reg, offset_next;
    logic [15:0]               sum_reg, sum_next, sum_put;
    logic [15:0]               stored_reg, stored_next, stored_put;
    logic [15:0]               length_reg, length_next, length_put;
    logic [2:0]                err_reg, err_next, err_eff;
    logic [1:0]                kind_reg, kind_next, kind_eff;
    elapchk_pkg::slots_t       slots_reg, slots_next, slots_put, slots_clr;
    elapchk_pkg::class_t       class_now;
    elapchk_pkg::result_t      res_comb, result_reg;
    logic                      result_valid_reg;

    logic                      take;
    logic                      slot_we;
    logic [3:0]                slot_idx;
    logic                      do_class;
    logic [9:0]                dlen;
    logic [9:0]                count;
    logic [OW-1:0]             sum_end;
    logic                      sum_hit;
    logic [16:0]               sum_add;
    logic [15:0]               calc_sum;
    logic                      sum_bad;

    assign take        = frame_valid && !frame_stall;
    assign frame_stall = result_valid_reg && result_stall && last_byte;

    // Header capture: decode the byte offset into a slot, length or checksum write.
    always_comb
    begin
        slot_we    = 1'b0;
        slot_idx   = 4'd0;
        length_put = length_reg;
        stored_put = stored_reg;
        if (offset_reg < elapchk_pkg::OFS_LENGTH)
        begin
            if (offset_reg >= elapchk_pkg::OFS_LLC)
            begin
                slot_we  = 1'b1;
                slot_idx = 4'(offset_reg - elapchk_pkg::OFS_LLC);
            end
        end
        else if (offset_reg < elapchk_pkg::OFS_CHECKSUM)
        begin
            length_put = {length_reg[7:0], frame_byte};
        end
        else if (offset_reg < elapchk_pkg::OFS_BODY)
        begin
            stored_put = {stored_reg[7:0], frame_byte};
        end
        else if (kind_reg == elapchk_pkg::KIND_DDP)
        begin
            if (offset_reg <= elapchk_pkg::OFS_DDP_END)
            begin
                slot_we  = 1'b1;
                slot_idx = 4'(offset_reg - elapchk_pkg::OFS_BODY);
            end
        end
        else if (kind_reg == elapchk_pkg::KIND_AARP)
        begin
            if (offset_reg <= elapchk_pkg::OFS_AARP_A0)
            begin
                slot_we  = 1'b1;
                slot_idx = 4'(offset_reg - elapchk_pkg::OFS_BODY);
            end
            else if (offset_reg >= elapchk_pkg::OFS_AARP_B &&
                     offset_reg <= elapchk_pkg::OFS_AARP_B1)
            begin
                slot_we  = 1'b1;
                slot_idx = 4'(offset_reg - elapchk_pkg::AARP_B_BASE);
            end
            else if (offset_reg >= elapchk_pkg::OFS_AARP_C &&
                     offset_reg <= elapchk_pkg::OFS_AARP_C1)
            begin
                slot_we  = 1'b1;
                slot_idx = 4'(offset_reg - elapchk_pkg::AARP_C_BASE);
            end
        end
        slots_put = slots_reg;
        if (slot_we)
        begin
            slots_put[slot_idx] = frame_byte;
        end
    end

    // Classification at the last SNAP byte, or at an early end of frame.
    // The slots are freed once the LLC/SNAP bytes have been classified.
    assign class_now = elapchk_pkg::classify(slots_put);
    assign do_class  = (offset_reg == elapchk_pkg::OFS_CLASSIFY) ||
                       (last_byte && offset_reg < elapchk_pkg::OFS_CLASSIFY);
    assign err_eff   = do_class ? class_now.err  : err_reg;
    assign kind_eff  = do_class ? class_now.kind : kind_reg;
    assign slots_clr = do_class ? '0 : slots_put;

    // Rotate-add checksum over the DDP bytes after the checksum field.
    assign dlen     = length_reg[9:0];
    assign count    = (dlen > elapchk_pkg::DDP_HDR_SUM_SKIP) ?
                      (dlen - elapchk_pkg::DDP_HDR_SUM_SKIP) : 10'd0;
    assign sum_end  = OW'(count) + elapchk_pkg::OFS_BODY;
    assign sum_hit  = (offset_reg >= elapchk_pkg::OFS_BODY) && (offset_reg < sum_end);
    assign sum_add  = {1'b0, sum_reg} + {9'd0, frame_byte};
    assign sum_put  = sum_hit ? {sum_add[14:0], sum_add[15]} : sum_reg;
    assign calc_sum = (sum_put == 16'd0) ? 16'hFFFF : sum_put;
    assign sum_bad  = (stored_put != 16'd0) &&
                      (({1'b0, offset_reg} + (OW+1)'(1) < {1'b0, sum_end}) ||
                       (calc_sum != stored_put));

    // Result of the frame, as seen with the current byte included.
    always_comb
    begin
        res_comb = '0;
        if (offset_reg < min_frame_reg)
        begin
            res_comb.status = elapchk_pkg::ST_SHORT;
        end
        else if (err_eff != elapchk_pkg::ST_OK)
        begin
            res_comb.status = err_eff;
        end
        else if (kind_eff == elapchk_pkg::KIND_DDP)
        begin
            res_comb.frame_kind  = elapchk_pkg::KIND_DDP;
            res_comb.ddp_length  = dlen;
            res_comb.hop_count   = length_put[13:10];
            res_comb.packet_code = {8'd0, slots_clr[8]};
            if (sum_bad)
            begin
                res_comb.status = elapchk_pkg::ST_BAD_SUM;
            end
            else
            begin
                res_comb.dest_net    = {slots_clr[0], slots_clr[1]};
                res_comb.src_net     = {slots_clr[2], slots_clr[3]};
                res_comb.dest_node   = slots_clr[4];
                res_comb.src_node    = slots_clr[5];
                res_comb.dest_socket = slots_clr[6];
                res_comb.src_socket  = slots_clr[7];
            end
        end
        else
        begin
            res_comb.frame_kind = elapchk_pkg::KIND_AARP;
            if (length_put != elapchk_pkg::AARP_HW_ETHER ||
                stored_put != elapchk_pkg::TYPE_DDP ||
                slots_clr[0] != elapchk_pkg::AARP_HW_LEN ||
                slots_clr[1] != elapchk_pkg::AARP_PROTO_LEN)
            begin
                res_comb.status = elapchk_pkg::ST_BAD_AARP;
            end
            else
            begin
                res_comb.packet_code = {slots_clr[2], slots_clr[3]};
                res_comb.src_socket  = slots_clr[4];
                res_comb.src_net     = {slots_clr[5], slots_clr[6]};
                res_comb.src_node    = slots_clr[7];
                res_comb.dest_socket = slots_clr[8];
                res_comb.dest_net    = {slots_clr[9], slots_clr[10]};
                res_comb.dest_node   = slots_clr[11];
            end
        end
    end

    // Next frame state; everything clears once the last byte is taken.
    always_comb
    begin
        if (last_byte)
        begin
            offset_next = '0;
            sum_next    = '0;
            stored_next = '0;
            length_next = '0;
            err_next    = elapchk_pkg::ST_OK;
            kind_next   = elapchk_pkg::KIND_NONE;
            slots_next  = '0;
        end
        else
        begin
            offset_next = (offset_reg < elapchk_pkg::OFFSET_MAX) ?
                          offset_reg + OW'(1) : offset_reg;
            sum_next    = sum_put;
            stored_next = stored_put;
            length_next = length_put;
            err_next    = err_eff;
            kind_next   = kind_eff;
            slots_next  = slots_clr;
        end
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_frame_reg <= elapchk_pkg::MIN_FRAME_RESET;
        end
        else if (cfg_we)
        begin
            min_frame_reg <= cfg_wdata;
        end
    end

    // Frame state registers, updated on every byte transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            sum_reg    <= '0;
            stored_reg <= '0;
            length_reg <= '0;
            err_reg    <= elapchk_pkg::ST_OK;
            kind_reg   <= elapchk_pkg::KIND_NONE;
            slots_reg  <= '0;
        end
        else if (take)
        begin
            offset_reg <= offset_next;
            sum_reg    <= sum_next;
            stored_reg <= stored_next;
            length_reg <= length_next;
            err_reg    <= err_next;
            kind_reg   <= kind_next;
            slots_reg  <= slots_next;
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (take && last_byte)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (take && last_byte)
        begin
            result_reg <= res_comb;
        end
    end

    assign result_valid = result_valid_reg;
    assign status       = result_reg.status;
    assign frame_kind   = result_reg.frame_kind;
    assign ddp_length   = result_reg.ddp_length;
    assign hop_count    = result_reg.hop_count;
    assign packet_code  = result_reg.packet_code;
    assign src_net      = result_reg.src_net;
    assign dest_net     = result_reg.dest_net;
    assign src_node     = result_reg.src_node;
    assign dest_node    = result_reg.dest_node;
    assign src_socket   = result_reg.src_socket;
    assign dest_socket  = result_reg.dest_socket;

`ifndef SYNTHESIS
    // A last-byte transfer always brings up a result in the next cycle.
    a_result_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
        take && last_byte |=> result_valid)
        else $error("no result after last byte transfer");

    // The frame state starts over after a last-byte transfer.
    a_offset_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        take && last_byte |=> offset_reg == '0 && kind_reg == elapchk_pkg::KIND_NONE)
        else $error("frame state not cleared after end of frame");

    // Input is only held back while a result is pending.
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        frame_stall |-> result_valid_reg)
        else $error("frame stalled without a pending result");

    // A short frame, or one rejected for its SAP, control or SNAP type, reports no frame kind.
    a_error_no_kind: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status == elapchk_pkg::ST_SHORT ||
                         status == elapchk_pkg::ST_BAD_SAP ||
                         status == elapchk_pkg::ST_BAD_CTRL ||
                         status == elapchk_pkg::ST_BAD_TYPE)
        |-> frame_kind == elapchk_pkg::KIND_NONE)
        else $error("frame kind set on a rejected frame");
`endif

endmodule

// ===== sim/tb_elap_ddp_aarp_frame_checker.sv =====
// Testbench for the ELAP frame checker: directed and random DDP/AARP frames.
`timescale 1ns / 1ps

// SNAP organization codes that select DDP and AARP.
localparam logic [23:0] DDP_OUI  = 24'h080007;
localparam logic [23:0] AARP_OUI = 24'h000000;

// Predicts the report of each frame from the bytes the checker takes, and checks
// every report the checker delivers against the oldest prediction.
class frame_verdict_board;
    logic [10:0] min_len;
    logic [10:0] offset;
    logic [15:0] sum_acc;
    logic [15:0] rx_sum;
    logic [15:0] len_word;
    logic [2:0]  err;
    logic [1:0]  kind;
    logic [7:0]  slot [16];
    elapchk_pkg::result_t due[$];
    int unsigned n_errors;
    int unsigned n_checked;
    int unsigned by_status [8];

    function new();
        min_len = elapchk_pkg::MIN_FRAME_RESET;
        n_errors = 0;
        n_checked = 0;
        foreach (by_status[i]) by_status[i] = 0;
        clear_frame();
    endfunction

    // One step of the DDP rotate-add checksum: add the byte, then rotate left by one.
    static function logic [15:0] rotate_add(input logic [15:0] acc, input logic [7:0] b);
        logic [16:0] t;
        t = {1'b0, acc} + {9'h000, b};
        return {t[14:0], t[15]};
    endfunction

    function void clear_frame();
        offset = '0;
        sum_acc = '0;
        rx_sum = '0;
        len_word = '0;
        err = elapchk_pkg::ST_OK;
        kind = elapchk_pkg::KIND_NONE;
        foreach (slot[i]) slot[i] = 8'h00;
    endfunction

    // Classify from the LLC/SNAP bytes in slots 0 to 7, then free the slots.
    function void classify_llc();
        logic [15:0] ptype;
        logic [23:0] oui;
        ptype = {slot[6], slot[7]};
        oui = {slot[3], slot[4], slot[5]};
        err = elapchk_pkg::ST_OK;
        kind = elapchk_pkg::KIND_NONE;
        if (slot[0] != elapchk_pkg::SAP_SNAP || slot[1] != elapchk_pkg::SAP_SNAP)
            err = elapchk_pkg::ST_BAD_SAP;
        else if (slot[2] != elapchk_pkg::LLC_UI)
            err = elapchk_pkg::ST_BAD_CTRL;
        else if (ptype == elapchk_pkg::TYPE_DDP && oui == DDP_OUI)
            kind = elapchk_pkg::KIND_DDP;
        else if (ptype == elapchk_pkg::TYPE_AARP && oui == AARP_OUI)
            kind = elapchk_pkg::KIND_AARP;
        else
            err = elapchk_pkg::ST_BAD_TYPE;
        foreach (slot[i]) slot[i] = 8'h00;
    endfunction

    // Account for one transferred byte; the last byte of a frame queues its report.
    function void note_byte(input logic [7:0] b, input logic lst);
        int unsigned o;
        int unsigned cnt;
        logic [9:0] dlen;
        logic [15:0] calc;
        elapchk_pkg::result_t r;
        o = offset;
        // The datagram length is taken as it stood before this byte.
        dlen = len_word[9:0];
        cnt = (dlen > 10'd4) ? dlen - 4 : 0;

        // Header capture by offset.
        if (o < 22)
        begin
            if (o >= 14)
                slot[o - 14] = b;
            if (o == 21)
                classify_llc();
        end
        else if (o < 24)
            len_word = {len_word[7:0], b};
        else if (o < 26)
            rx_sum = {rx_sum[7:0], b};
        else if (kind == elapchk_pkg::KIND_DDP)
        begin
            if (o <= 34)
                slot[o - 26] = b;
        end
        else if (kind == elapchk_pkg::KIND_AARP)
        begin
            if (o <= 29)
                slot[o - 26] = b;
            else if (o >= 36 && o <= 39)
                slot[o - 32] = b;
            else if (o >= 46 && o <= 49)
                slot[o - 38] = b;
        end

        // Checksum covers the datagram bytes after the checksum field.
        if (o >= 26 && o - 26 < cnt)
            sum_acc = rotate_add(sum_acc, b);

        if (o < elapchk_pkg::OFFSET_MAX)
            offset = 11'(o + 1);

        if (!lst)
            return;

        r = '0;
        if (o + 1 <= min_len)
            r.status = elapchk_pkg::ST_SHORT;
        else
        begin
            // A frame that ends before the SNAP type is classified on what it has.
            if (o < 21)
                classify_llc();
            if (err != elapchk_pkg::ST_OK)
                r.status = err;
            else if (kind == elapchk_pkg::KIND_DDP)
            begin
                r.frame_kind = elapchk_pkg::KIND_DDP;
                r.ddp_length = dlen;
                r.hop_count = len_word[13:10];
                r.packet_code = {8'h00, slot[8]};
                calc = (sum_acc == 16'h0000) ? 16'hFFFF : sum_acc;
                if (rx_sum != 16'h0000 && (o + 1 < 26 + cnt || calc != rx_sum))
                    r.status = elapchk_pkg::ST_BAD_SUM;
                else
                begin
                    r.dest_net = {slot[0], slot[1]};
                    r.src_net = {slot[2], slot[3]};
                    r.dest_node = slot[4];
                    r.src_node = slot[5];
                    r.dest_socket = slot[6];
                    r.src_socket = slot[7];
                end
            end
            else
            begin
                r.frame_kind = elapchk_pkg::KIND_AARP;
                if (len_word != elapchk_pkg::AARP_HW_ETHER ||
                    rx_sum != elapchk_pkg::TYPE_DDP ||
                    slot[0] != elapchk_pkg::AARP_HW_LEN ||
                    slot[1] != elapchk_pkg::AARP_PROTO_LEN)
                    r.status = elapchk_pkg::ST_BAD_AARP;
                else
                begin
                    r.packet_code = {slot[2], slot[3]};
                    r.src_socket = slot[4];
                    r.src_net = {slot[5], slot[6]};
                    r.src_node = slot[7];
                    r.dest_socket = slot[8];
                    r.dest_net = {slot[9], slot[10]};
                    r.dest_node = slot[11];
                end
            end
        end
        due.push_back(r);
        clear_frame();
    endfunction

    function void compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            n_errors++;
        end
    endfunction

    // Check a delivered report against the oldest outstanding frame.
    function void check_verdict(input elapchk_pkg::result_t got);
        elapchk_pkg::result_t want;
        if (due.size() == 0)
        begin
            $error("Report delivered with no frame outstanding (status %0d).", got.status);
            n_errors++;
            return;
        end
        want = due.pop_front();
        n_checked++;
        by_status[want.status]++;
        compare_field("status", want.status, got.status);
        compare_field("frame_kind", want.frame_kind, got.frame_kind);
        compare_field("ddp_length", want.ddp_length, got.ddp_length);
        compare_field("hop_count", want.hop_count, got.hop_count);
        compare_field("packet_code", want.packet_code, got.packet_code);
        compare_field("src_net", want.src_net, got.src_net);
        compare_field("dest_net", want.dest_net, got.dest_net);
        compare_field("src_node", want.src_node, got.src_node);
        compare_field("dest_node", want.dest_node, got.dest_node);
        compare_field("src_socket", want.src_socket, got.src_socket);
        compare_field("dest_socket", want.dest_socket, got.dest_socket);
    endfunction
endclass

module tb_elap_ddp_aarp_frame_checker;

    localparam int CYCLE_LIMIT  = 20000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 4;
    localparam int PHASE_FRAMES = 3;
    localparam int PHASE_COUNT  = 4;
    localparam logic [10:0] PHASE_MIN [PHASE_COUNT] =
        '{11'd0, 11'd30, 11'd14, 11'd60};

    typedef enum {SUM_OFF, SUM_GOOD, SUM_BAD} sum_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [10:0] cfg_wdata = '0;
    logic        frame_valid = 1'b0;
    logic        frame_stall;
    logic [7:0]  frame_byte = '0;
    logic        last_byte = 1'b0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [2:0]  status;
    logic [1:0]  frame_kind;
    logic [9:0]  ddp_length;
    logic [3:0]  hop_count;
    logic [15:0] packet_code;
    logic [15:0] src_net;
    logic [15:0] dest_net;
    logic [7:0]  src_node;
    logic [7:0]  dest_node;
    logic [7:0]  src_socket;
    logic [7:0]  dest_socket;
    elapchk_pkg::result_t seen;

    frame_verdict_board verdicts;
    logic [7:0]  frame_q[$];
    int          gap_pct = 12;
    int          stall_pct = 12;
    int          hold_ticket = 0;
    int unsigned cycle_count = 0;
    int unsigned n_frames = 0;
    int unsigned n_bytes = 0;
    int unsigned n_settings = 0;

    elap_ddp_aarp_frame_checker DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .frame_valid  (frame_valid),
        .frame_stall  (frame_stall),
        .frame_byte   (frame_byte),
        .last_byte    (last_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .frame_kind   (frame_kind),
        .ddp_length   (ddp_length),
        .hop_count    (hop_count),
        .packet_code  (packet_code),
        .src_net      (src_net),
        .dest_net     (dest_net),
        .src_node     (src_node),
        .dest_node    (dest_node),
        .src_socket   (src_socket),
        .dest_socket  (dest_socket)
    );

    assign seen = {status, frame_kind, ddp_length, hop_count, packet_code, src_net,
                   dest_net, src_node, dest_node, src_socket, dest_socket};

    // 50 MHz clock.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watch both channels at the rising edge; a transfer is valid with no stall.
    always @(posedge clk)
    begin
        if (rst_n && frame_valid && !frame_stall)
            verdicts.note_byte(frame_byte, last_byte);
        if (rst_n && result_valid && !result_stall)
            verdicts.check_verdict(seen);
    end

    // Guard against a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $error("Timed out after %0d cycles with %0d reports outstanding.",
                   cycle_count, verdicts.due.size());
            $display("FAIL");
            $finish;
        end
    end

    // Report consumer: random stalls, plus a long hold-off whenever one is requested.
    initial
    begin
        int hold_left;
        int served;
        hold_left = 0;
        served = 0;
        forever
        begin
            @(negedge clk);
            if (served != hold_ticket)
            begin
                served = hold_ticket;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= ($urandom_range(99, 0) < stall_pct);
        end
    end

    // Offer one byte, idling at random first, and hold it until it is transferred.
    task automatic put_byte(input logic [7:0] b, input logic lst);
        while (gap_pct > 0 && $urandom_range(99, 0) < gap_pct)
        begin
            frame_valid = 1'b0;
            frame_byte = 8'($urandom);
            @(negedge clk);
        end
        frame_valid = 1'b1;
        frame_byte = b;
        last_byte = lst;
        @(posedge clk);
        while (frame_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_frame();
        foreach (frame_q[i])
            put_byte(frame_q[i], i == frame_q.size() - 1);
        n_frames++;
        n_bytes += frame_q.size();
    endtask

    // Drop the offer and wait until every outstanding report has come back.
    task automatic wait_idle();
        frame_valid = 1'b0;
        while (verdicts.due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_min_len(input logic [10:0] v);
        wait_idle();
        cfg_we = 1'b1;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we = 1'b0;
        verdicts.min_len = v;
        n_settings++;
    endtask

    task automatic add_random(input int n);
        repeat (n) frame_q.push_back(8'($urandom));
    endtask

    task automatic pad_to(input int n);
        if (frame_q.size() < n)
            add_random(n - frame_q.size());
    endtask

    task automatic trim_frame(input int keep);
        while (frame_q.size() > keep)
            void'(frame_q.pop_back());
    endtask

    // MAC header with random addresses, then LLC and SNAP.
    task automatic start_llc(input logic [23:0] oui, input logic [15:0] ptype);
        frame_q.delete();
        add_random(14);
        frame_q.push_back(elapchk_pkg::SAP_SNAP);
        frame_q.push_back(elapchk_pkg::SAP_SNAP);
        frame_q.push_back(elapchk_pkg::LLC_UI);
        frame_q.push_back(oui[23:16]);
        frame_q.push_back(oui[15:8]);
        frame_q.push_back(oui[7:0]);
        frame_q.push_back(ptype[15:8]);
        frame_q.push_back(ptype[7:0]);
    endtask

    // DDP datagram of the given length with random content and a chosen checksum.
    task automatic build_ddp(input logic [9:0] dlen, input logic [3:0] hops,
                             input sum_mode_t mode, input int min_size);
        int cnt;
        logic [15:0] acc;
        logic [15:0] sent;
        start_llc(DDP_OUI, elapchk_pkg::TYPE_DDP);
        frame_q.push_back({2'($urandom), hops, dlen[9:8]});
        frame_q.push_back(dlen[7:0]);
        frame_q.push_back(8'h00);
        frame_q.push_back(8'h00);
        cnt = (dlen > 10'd4) ? int'(dlen) - 4 : 0;
        add_random(cnt);
        acc = '0;
        for (int i = 0; i < cnt; i++)
            acc = verdicts.rotate_add(acc, frame_q[26 + i]);
        if (acc == 16'h0000)
            acc = 16'hFFFF;
        case (mode)
            SUM_OFF:  sent = 16'h0000;
            SUM_GOOD: sent = acc;
            default:  sent = acc ^ 16'($urandom_range(65535, 1));
        endcase
        frame_q[24] = sent[15:8];
        frame_q[25] = sent[7:0];
        pad_to(min_size);
    endtask

    // AARP packet with random function and addresses; bad_at corrupts one header byte.
    task automatic build_aarp(input int bad_at, input int min_size);
        start_llc(AARP_OUI, elapchk_pkg::TYPE_AARP);
        frame_q.push_back(elapchk_pkg::AARP_HW_ETHER[15:8]);
        frame_q.push_back(elapchk_pkg::AARP_HW_ETHER[7:0]);
        frame_q.push_back(elapchk_pkg::TYPE_DDP[15:8]);
        frame_q.push_back(elapchk_pkg::TYPE_DDP[7:0]);
        frame_q.push_back(elapchk_pkg::AARP_HW_LEN);
        frame_q.push_back(elapchk_pkg::AARP_PROTO_LEN);
        add_random(22);
        if (bad_at >= 0)
            frame_q[bad_at] ^= 8'($urandom_range(255, 1));
        pad_to(min_size);
    endtask

    // Mostly well-formed frames with random content, the rest broken or noise.
    task automatic random_frame();
        int pick;
        int r;
        int bad_at;
        sum_mode_t mode;
        logic [9:0] dlen;
        pick = $urandom_range(99, 0);
        r = $urandom_range(99, 0);
        mode = (r < 20) ? SUM_OFF : (r < 80) ? SUM_GOOD : SUM_BAD;
        dlen = 10'($urandom_range(40, 0));
        bad_at = -1;
        if ($urandom_range(3, 0) == 0)
            bad_at = $urandom_range(27, 22);
        if (pick < 45)
        begin
            build_ddp(dlen, 4'($urandom), mode, $urandom_range(60, 26));
            if ($urandom_range(99, 0) < 15)
                trim_frame($urandom_range(frame_q.size(), 1));
        end
        else if (pick < 70)
        begin
            build_aarp(bad_at, $urandom_range(60, 26));
            if ($urandom_range(99, 0) < 10)
                trim_frame($urandom_range(frame_q.size(), 1));
        end
        else if (pick < 85)
        begin
            if ($urandom_range(1, 0) == 0)
                build_ddp(dlen, 4'($urandom), mode, $urandom_range(60, 26));
            else
                build_aarp(-1, $urandom_range(60, 26));
            frame_q[$urandom_range(21, 14)] ^= 8'($urandom_range(255, 1));
        end
        else
        begin
            frame_q.delete();
            add_random($urandom_range(60, 1));
        end
        send_frame();
    endtask

    initial
    begin
        verdicts = new();
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Under the reset minimum of 60 bytes, a frame of exactly 60 is short.
        build_ddp(10'd20, 4'h2, SUM_GOOD, 60);
        send_frame();
        build_ddp(10'd20, 4'h2, SUM_GOOD, 61);
        send_frame();

        // With no minimum: checksum modes, truncation and malformed headers.
        set_min_len(11'd0);
        build_ddp(10'd24, 4'hF, SUM_GOOD, 0);
        send_frame();
        build_ddp(10'd24, 4'h0, SUM_OFF, 0);
        send_frame();
        build_ddp(10'd24, 4'h5, SUM_BAD, 0);
        send_frame();
        // Datagram cut off before all checksummed bytes arrive.
        build_ddp(10'd200, 4'h3, SUM_GOOD, 0);
        trim_frame(40);
        send_frame();
        // Lengths below 4 checksum nothing, so only 0xFFFF matches.
        build_ddp(10'd2, 4'h1, SUM_GOOD, 0);
        send_frame();
        build_ddp(10'd3, 4'h1, SUM_BAD, 0);
        send_frame();
        build_aarp(-1, 0);
        send_frame();
        build_aarp(26, 0);
        send_frame();
        // Broken SAP, control and SNAP type.
        build_aarp(-1, 0);
        frame_q[14] ^= 8'h01;
        send_frame();
        build_aarp(-1, 0);
        frame_q[16] ^= 8'h80;
        send_frame();
        build_ddp(10'd30, 4'h7, SUM_GOOD, 0);
        frame_q[20] ^= 8'h40;
        send_frame();
        frame_q.delete();
        repeat (30) frame_q.push_back(8'hFF);
        send_frame();
        // Truncated headers, including an end inside the length field.
        frame_q.delete();
        frame_q.push_back(8'h5A);
        send_frame();
        build_ddp(10'd40, 4'h4, SUM_GOOD, 0);
        trim_frame(18);
        send_frame();
        build_ddp(10'd40, 4'h4, SUM_GOOD, 0);
        trim_frame(22);
        send_frame();
        build_ddp(10'd40, 4'h4, SUM_GOOD, 0);
        trim_frame(23);
        send_frame();
        build_aarp(-1, 0);
        trim_frame(40);
        send_frame();

        // Random phases over several minimum lengths and flow-control patterns.
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            set_min_len((ph == 3) ? 11'($urandom_range(80, 0)) : PHASE_MIN[ph]);
            gap_pct = (ph == 2) ? 0 : 12;
            stall_pct = (ph == 2) ? 0 : 12;
            if (ph == 1)
            begin
                @(posedge clk);
                hold_ticket++;
                @(negedge clk);
            end
            repeat (PHASE_FRAMES) random_frame();
        end

        wait_idle();
        repeat (8) @(negedge clk);
        $display("Run covered %0d frames (%0d bytes) over %0d min-length settings;",
                 n_frames, n_bytes, n_settings + 1);
        $display("%0d reports checked: ok %0d, short %0d, SAP %0d, control %0d, type %0d,",
                 verdicts.n_checked, verdicts.by_status[0], verdicts.by_status[1],
                 verdicts.by_status[2], verdicts.by_status[3], verdicts.by_status[4]);
        $display("checksum %0d, AARP %0d.", verdicts.by_status[5], verdicts.by_status[6]);
        if (verdicts.n_errors == 0 && verdicts.due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/elapchk_pkg.sv
src/elap_ddp_aarp_frame_checker.sv
sim/tb_elap_ddp_aarp_frame_checker.sv
